FILE: src/pat_pkg.sv
package pat_pkg;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_POS   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // index width that covers the largest supported table, count included
  localparam int IDX_W = 11;

  // match lanes the scanner inspects per cycle
  localparam int LANES = 8;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
    logic [6:0]         position;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] found_position;
    logic [6:0] fill_count;
  } out_t;

  // broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [31:0]      word;
    logic [IDX_W-1:0] pos0;
    logic [IDX_W-1:0] cnt;
  } cmd_t;

  // scanner status toward the controller
  typedef struct packed {
    logic             busy;
    logic             done;
    logic             found;
    logic [IDX_W-1:0] pos;
  } scan_res_t;

endpackage

FILE: src/pat_cell.sv
module pat_cell #(
  parameter int IDX = 0
) (
  input  logic          clk_i,
  input  pat_pkg::cmd_t cmd_i,
  input  logic [31:0]   left_i,
  input  logic [31:0]   right_i,
  output logic [31:0]   data_o,
  output logic          match_o
);
  import pat_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [31:0] data_q;
  logic        at_or_above;

  assign at_or_above = MY_IDX >= cmd_i.pos0;

  // insert moves the lower neighbor up, delete pulls the upper neighbor down
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins && at_or_above) begin
      data_q <= (MY_IDX == cmd_i.pos0) ? cmd_i.word : left_i;
    end else if (cmd_i.del && at_or_above) begin
      data_q <= right_i;
    end
  end

  assign data_o  = data_q;
  assign match_o = (data_q == cmd_i.word) && (MY_IDX < cmd_i.cnt);

endmodule

FILE: src/pat_scan.sv
module pat_scan #(
  parameter int DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DEPTH-1:0]   match_i,
  output pat_pkg::scan_res_t res_o
);
  import pat_pkg::*;

  localparam int NCH  = (DEPTH + LANES - 1) / LANES;
  localparam int VW   = NCH * LANES;
  localparam int LW   = $clog2(LANES);
  localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam logic [CHW-1:0] LAST_CH = CHW'(NCH - 1);

  logic [VW-1:0]    vec_q, vec_d;
  logic [CHW-1:0]   chunk_q;
  logic             busy_q;
  logic [LANES-1:0] low;
  logic             hit;
  logic             last;
  logic [LW-1:0]    ff;

  assign low  = vec_q[LANES-1:0];
  assign hit  = |low;
  assign last = chunk_q == LAST_CH;

  // lowest set lane
  always_comb begin
    ff = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (low[i]) begin
        ff = LW'(i);
      end
    end
  end

  always_comb begin
    vec_d = '0;
    vec_d[DEPTH-1:0] = match_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && (hit || last)) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      vec_q   <= vec_d;
      chunk_q <= '0;
    end else if (busy_q) begin
      vec_q   <= vec_q >> LANES;
      chunk_q <= chunk_q + CHW'(1);
    end
  end

  assign res_o.busy  = busy_q;
  assign res_o.done  = busy_q && (hit || last);
  assign res_o.found = hit;
  assign res_o.pos   = IDX_W'({chunk_q, ff}) + IDX_W'(1);

endmodule

FILE: src/positional_array_table_unit.sv
// positional array table: an ordered list of up to DEPTH 32-bit words
//
// input channel (in_valid_i / in_stall_o / in_data_i) carries one operation
// per transaction: insert at a 1-based position, delete at a position, or
// search for a word. output channel (out_valid_o / out_stall_i / out_data_o)
// returns exactly one result transaction per operation, in order.
//
// insert, delete and rejected operations: result is registered in the cycle
// after acceptance, and a new transaction is taken every cycle as long as
// the output register drains.
// search: all cells compare at once, then a scanner walks the match flags
// eight lanes per cycle to find the first hit. no new transaction is taken
// while a search scans.
//
// reset clears the fill count and the output valid; table words stay
// undefined and are never read before written, so there is no clearing pass.
// a stalled result stays in the output register; the input side stalls
// until that result is taken.
module positional_array_table_unit #(
  parameter int DEPTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pat_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pat_pkg::out_t out_data_o
);
  import pat_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  // controller states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic             state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  out_t             out_q;

  logic             in_acc;
  logic [IDX_W-1:0] pos_w;
  logic [IDX_W-1:0] cnt_w;
  logic             ins_ok, del_ok, full;
  logic             srch_go;
  logic             imm_go;
  logic [1:0]       imm_status;
  cmd_t             cmd;
  scan_res_t        scan;

  logic [31:0]      cell_data [DEPTH];
  logic [DEPTH-1:0] match;

  // accept only when idle and the output register is free or being drained
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  // position checks
  assign pos_w  = IDX_W'(in_data_i.position);
  assign cnt_w  = IDX_W'(count_q);
  assign ins_ok = (pos_w != '0) && (pos_w <= cnt_w + IDX_W'(1));
  assign del_ok = (pos_w != '0) && (pos_w <= cnt_w);
  assign full   = count_q == CNT_W'(DEPTH);

  // broadcast command for the cell row
  assign cmd.ins  = in_acc && (in_data_i.operation == OP_INSERT) && ins_ok && !full;
  assign cmd.del  = in_acc && (in_data_i.operation == OP_DELETE) && del_ok;
  assign cmd.word = $unsigned(in_data_i.value);
  assign cmd.pos0 = pos_w - IDX_W'(1);
  assign cmd.cnt  = cnt_w;

  assign srch_go = in_acc && (in_data_i.operation == OP_SEARCH);
  assign imm_go  = in_acc && (in_data_i.operation != OP_SEARCH);

  // status for everything that answers right away
  always_comb begin
    case (in_data_i.operation)
      OP_INSERT: imm_status = !ins_ok ? ST_BAD_POS : (full ? ST_FULL : ST_OK);
      OP_DELETE: imm_status = del_ok ? ST_OK : ST_BAD_POS;
      default:   imm_status = ST_BAD_POS;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd.del) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (srch_go) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan.done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // row of cells, each neighbor wired to the next
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [31:0] left_w;
    logic [31:0] right_w;
    if (k == 0) begin : g_first
      assign left_w = cmd.word;
    end else begin : g_mid_l
      assign left_w = cell_data[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_w = cell_data[k];
    end else begin : g_mid_r
      assign right_w = cell_data[k+1];
    end
    pat_cell #(
      .IDX (k)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[k]),
      .match_o (match[k])
    );
  end

  pat_scan #(
    .DEPTH (DEPTH)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (srch_go),
    .match_i (match),
    .res_o   (scan)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (imm_go || (state_q == S_SCAN && scan.done)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (imm_go) begin
      out_q.status         <= imm_status;
      out_q.found_position <= '0;
      out_q.fill_count     <= 7'(count_d);
    end else if (state_q == S_SCAN && scan.done) begin
      out_q.status         <= scan.found ? ST_OK : ST_NOT_FOUND;
      out_q.found_position <= scan.found ? 7'(scan.pos) : 7'd0;
      out_q.fill_count     <= 7'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // fill count stays within the table
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  // scanner runs exactly while the controller waits on it
  a_scan_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan.busy == (state_q == S_SCAN))
    else $error("scanner and controller disagree");

  // a performed insert grows the table by one
  a_ins_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not grow the table");

  // a finished search always lands in a free output register
  a_scan_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && scan.done) |-> !(out_valid_q && out_stall_i))
    else $error("search result would overwrite a pending transaction");

endmodule

FILE: tb/sv/positional_array_table_unit_tb.sv
module positional_array_table_unit_tb;
  import pat_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int RANDOM_ITEMS = 1500;
  localparam int STALL_LIMIT = 4000;   // cycles with no transaction on either side
  localparam int SETTLE_CYCLES = 40;   // search scan plus output register, with margin

  // operation code the block has no use for
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_ANY} mix_e;

  // mirror of the table: applies each accepted operation and queues its answer
  class table_scoreboard;
    logic [31:0] words [TABLE_DEPTH];
    int          fill;
    out_t        pending_answers [$];
    int unsigned errors;
    int unsigned op_seen [4];
    int unsigned status_seen [4];
    int          peak_fill;

    function new();
      fill = 0;
      errors = 0;
      peak_fill = 0;
    endfunction

    function out_t apply_op(in_t item);
      out_t res;
      int   pos;
      bit   hit;
      res = '0;
      pos = int'(item.position);
      hit = 1'b0;
      case (item.operation)
        OP_INSERT: begin
          if (pos < 1 || pos > fill + 1) begin
            res.status = ST_BAD_POS;
          end else if (fill >= TABLE_DEPTH) begin
            res.status = ST_FULL;
          end else begin
            for (int k = fill; k >= pos; k--) words[k] = words[k-1];
            words[pos-1] = item.value;
            fill++;
            res.status = ST_OK;
          end
        end
        OP_DELETE: begin
          if (pos < 1 || pos > fill) begin
            res.status = ST_BAD_POS;
          end else begin
            for (int k = pos - 1; k + 1 < fill; k++) words[k] = words[k+1];
            fill--;
            res.status = ST_OK;
          end
        end
        OP_SEARCH: begin
          res.status = ST_NOT_FOUND;
          for (int k = 0; k < fill && !hit; k++) begin
            if (words[k] == item.value) begin
              hit = 1'b1;
              res.status = ST_OK;
              res.found_position = 7'(k + 1);
            end
          end
        end
        default: begin
          res.status = ST_BAD_POS;
        end
      endcase
      res.fill_count = 7'(fill);
      return res;
    endfunction

    function void note_input(in_t item);
      op_seen[item.operation]++;
      pending_answers.push_back(apply_op(item));
      if (fill > peak_fill) peak_fill = fill;
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_answers.size() == 0) begin
        $error("unexpected result transaction: status %0d found_position %0d fill_count %0d",
               got.status, got.found_position, got.fill_count);
        errors++;
        return;
      end
      want = pending_answers.pop_front();
      status_seen[want.status]++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.found_position !== want.found_position) begin
        $error("found_position: expected %0d, actual %0d",
               want.found_position, got.found_position);
        errors++;
      end
      if (got.fill_count !== want.fill_count) begin
        $error("fill_count: expected %0d, actual %0d", want.fill_count, got.fill_count);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_answers.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  table_scoreboard sb;
  bit              steady = 1'b0;  // no gaps and no stalls while set
  int unsigned     quiet_cycles = 0;

  positional_array_table_unit #(
    .DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // result side: check every accepted result against the oldest answer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // watchdog: a long run of cycles with no transaction means the block hung
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("positional_array_table_unit_tb: done, errors");
      $finish;
    end
  end

  // receiver back-pressure: mostly short runs, now and then a long stall
  initial begin
    int unsigned r;
    int unsigned len;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      r = $urandom_range(0, 99);
      if (steady || r < 60) begin
        out_stall_i <= 1'b0;
        len = $urandom_range(1, 6);
      end else if (r < 92) begin
        out_stall_i <= 1'b1;
        len = $urandom_range(1, 3);
      end else begin
        out_stall_i <= 1'b1;
        len = $urandom_range(10, 40);
      end
      repeat (len) @(posedge clk_i);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // duplicates from a small pool make first-match searches likely
  function automatic logic [31:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return 32'($urandom_range(1, 6));
    if (r < 45) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  function automatic in_t mk_item(logic [1:0] op, logic [31:0] word, logic [6:0] pos);
    in_t it;
    it.operation = op;
    it.value = word;
    it.position = pos;
    return it;
  endfunction

  // one random operation, biased by the phase toward growing or shrinking the table
  function automatic in_t make_op(mix_e mix);
    in_t         it;
    int unsigned r;
    int          f;
    logic [1:0]  op;
    f = sb.fill;
    r = $urandom_range(0, 99);
    it = mk_item(OP_SEARCH, pick_word(), 7'($urandom_range(0, 127)));
    // noise: any code, any position
    if (r < 8) begin
      it.operation = 2'($urandom_range(0, 3));
      return it;
    end
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  op = (r < 88) ? OP_INSERT : ((r < 94) ? OP_SEARCH : OP_DELETE);
      MIX_DRAIN: op = (r < 80) ? OP_DELETE : ((r < 92) ? OP_SEARCH : OP_INSERT);
      default:   op = (r < 35) ? OP_INSERT : ((r < 65) ? OP_DELETE : OP_SEARCH);
    endcase
    it.operation = op;
    case (op)
      OP_INSERT: begin
        // loading at the end is the common case
        if ($urandom_range(0, 2) == 0) it.position = 7'(f + 1);
        else it.position = 7'($urandom_range(1, f + 1));
      end
      OP_DELETE: begin
        if (f == 0) it.position = 7'($urandom_range(0, 3));
        else it.position = 7'($urandom_range(1, f));
      end
      default: begin
        if (f > 0 && $urandom_range(0, 9) < 6) it.value = sb.words[$urandom_range(0, f - 1)];
      end
    endcase
    return it;
  endfunction

  task automatic idle_in(int unsigned n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // present one transaction and hold it until the block takes it
  task automatic drive_op(in_t item);
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(item);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  initial begin
    in_t         script [$];
    int unsigned sent;
    int unsigned phase_no;
    int unsigned phase_len;
    mix_e        mix;

    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, bad positions, loading, front and middle inserts
    script.push_back(mk_item(OP_DELETE, 32'h0, 7'd1));
    script.push_back(mk_item(OP_SEARCH, 32'h0, 7'd0));
    script.push_back(mk_item(OP_INSERT, 32'h1, 7'd0));
    script.push_back(mk_item(OP_INSERT, 32'h1, 7'd2));
    script.push_back(mk_item(OP_INSERT, 32'h7fff_ffff, 7'd1));
    script.push_back(mk_item(OP_INSERT, 32'h8000_0000, 7'd2));
    script.push_back(mk_item(OP_INSERT, 32'h0000_0000, 7'd1));
    script.push_back(mk_item(OP_INSERT, 32'hffff_ffff, 7'd2));
    script.push_back(mk_item(OP_INSERT, 32'h5, 7'd5));
    script.push_back(mk_item(OP_INSERT, 32'h9, 7'd127));
    // duplicate word so the search must pick the lowest match
    script.push_back(mk_item(OP_INSERT, 32'h8000_0000, 7'd3));
    script.push_back(mk_item(OP_SEARCH, 32'h8000_0000, 7'd0));
    script.push_back(mk_item(OP_SEARCH, 32'h7fff_ffff, 7'd127));
    script.push_back(mk_item(OP_SEARCH, 32'd12345, 7'd64));
    script.push_back(mk_item(OP_UNUSED, 32'hffff_ffff, 7'd1));
    script.push_back(mk_item(OP_DELETE, 32'h0, 7'd0));
    script.push_back(mk_item(OP_DELETE, 32'h0, 7'd7));
    script.push_back(mk_item(OP_DELETE, 32'h0, 7'd127));
    script.push_back(mk_item(OP_DELETE, 32'h0, 7'd1));
    script.push_back(mk_item(OP_DELETE, 32'h0, 7'd5));
    script.push_back(mk_item(OP_DELETE, 32'h0, 7'd2));
    script.push_back(mk_item(OP_SEARCH, 32'hffff_ffff, 7'd0));
    script.push_back(mk_item(OP_SEARCH, 32'h8000_0000, 7'd0));

    foreach (script[i]) begin
      idle_in(pick_gap());
      drive_op(script[i]);
    end
    // let everything come back before the random part
    wait_drained();

    // random phases: the first one fills the table to the top and beyond,
    // one runs without any gaps, one ends with a full drain of results
    sent = 0;
    phase_no = 0;
    while (sent < RANDOM_ITEMS) begin
      mix = (phase_no == 0) ? MIX_FILL : mix_e'($urandom_range(0, 2));
      steady = (phase_no == 3);
      phase_len = (mix == MIX_FILL) ? $urandom_range(100, 160) : $urandom_range(40, 120);
      repeat (phase_len) begin
        idle_in(pick_gap());
        drive_op(make_op(mix));
        sent++;
      end
      if (phase_no == 5) wait_drained();
      phase_no++;
    end
    steady = 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("run: %0d inserts, %0d deletes, %0d searches, %0d unused codes; peak fill %0d of %0d",
             sb.op_seen[OP_INSERT], sb.op_seen[OP_DELETE], sb.op_seen[OP_SEARCH],
             sb.op_seen[OP_UNUSED], sb.peak_fill, TABLE_DEPTH);
    $display("answers: %0d ok, %0d bad position, %0d full, %0d not found",
             sb.status_seen[ST_OK], sb.status_seen[ST_BAD_POS],
             sb.status_seen[ST_FULL], sb.status_seen[ST_NOT_FOUND]);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("positional_array_table_unit_tb: done, clean");
    end else begin
      $display("positional_array_table_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
